/* hw/rtl/crt_pkg.sv */
// Package with shared constants, codes and item types of the cancel request tracker.
`default_nettype none

package crt_pkg;

  // Field widths.
  localparam int TAG_BITS     = 16;
  localparam int TIME_BITS    = 48;
  localparam int TIMEOUT_BITS = 32;
  localparam int ATTEMPT_BITS = 8;
  localparam int ACTION_BITS  = 3;
  localparam int STATUS_BITS  = 3;
  localparam int OUTCOME_BITS = 3;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 32;

  // Width used to compare elapsed time against the timeout.
  localparam int CMP_BITS = (TIME_BITS > TIMEOUT_BITS) ? TIME_BITS : TIMEOUT_BITS;

  // Reset values of the configuration registers.
  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET  = TIMEOUT_BITS'(5000);
  localparam logic [ATTEMPT_BITS-1:0] ATTEMPTS_RESET = ATTEMPT_BITS'(3);

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ACK_TIMEOUT  = 1'b0,
    REG_MAX_ATTEMPTS = 1'b1
  } cfg_reg_t;

  // Input actions.
  typedef enum logic [ACTION_BITS-1:0] {
    ACT_SENT   = 3'd0,
    ACT_RESENT = 3'd1,
    ACT_CLEAR  = 3'd2,
    ACT_ENTRY  = 3'd3,
    ACT_END    = 3'd4
  } action_t;

  // Result outcomes.
  typedef enum logic [OUTCOME_BITS-1:0] {
    OUT_NONE       = 3'd0,
    OUT_FINISHED   = 3'd1,
    OUT_FAILED     = 3'd2,
    OUT_RUNNING    = 3'd3,
    OUT_GONE       = 3'd4,
    OUT_UNANSWERED = 3'd5,
    OUT_RESEND     = 3'd6
  } outcome_t;

  // Entry status codes that end an action.
  localparam logic [STATUS_BITS-1:0] ST_FINISHED = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_FAILED   = 3'd5;

  // One input item.
  typedef struct packed {
    logic [ACTION_BITS-1:0] action;
    logic [TAG_BITS-1:0]    request_tag;
    logic [TAG_BITS-1:0]    order_tag;
    logic [STATUS_BITS-1:0] entry_status;
    logic                   order_has_work;
    logic [TIME_BITS-1:0]   report_time;
    logic [TIME_BITS-1:0]   time_now;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [OUTCOME_BITS-1:0] outcome;
    logic [STATUS_BITS-1:0]  reported_status;
    logic [TAG_BITS-1:0]     result_order_tag;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/crt_item_if.sv */
// Input item channel: valid/ready handshake with the item fields.
`default_nettype none

interface crt_item_if;
  import crt_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ACTION_BITS-1:0] action;
  logic [TAG_BITS-1:0]    request_tag;
  logic [TAG_BITS-1:0]    order_tag;
  logic [STATUS_BITS-1:0] entry_status;
  logic                   order_has_work;
  logic [TIME_BITS-1:0]   report_time;
  logic [TIME_BITS-1:0]   time_now;

  modport source (
    output valid, action, request_tag, order_tag, entry_status,
           order_has_work, report_time, time_now,
    input  ready
  );

  modport sink (
    input  valid, action, request_tag, order_tag, entry_status,
           order_has_work, report_time, time_now,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/crt_result_if.sv */
// Result channel: valid/ready handshake with the result fields.
`default_nettype none

interface crt_result_if;
  import crt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OUTCOME_BITS-1:0] outcome;
  logic [STATUS_BITS-1:0]  reported_status;
  logic [TAG_BITS-1:0]     result_order_tag;

  modport source (
    output valid, outcome, reported_status, result_order_tag,
    input  ready
  );

  modport sink (
    input  valid, outcome, reported_status, result_order_tag,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/crt_cfg_if.sv */
// Configuration write channel: valid/ready handshake with register index and data.
`default_nettype none

interface crt_cfg_if;
  import crt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/crt_core.sv */
// Tracker state, configuration registers and the per-item decision logic.
`default_nettype none

module crt_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [crt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [crt_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               step,
  input  crt_pkg::item_t                     item,
  output crt_pkg::result_t                   result
);
  import crt_pkg::*;

  // Configuration registers.
  logic [TIMEOUT_BITS-1:0] ack_timeout;
  logic [ATTEMPT_BITS-1:0] max_attempts;

  // Tracker state.
  logic                    pending, pending_next;
  logic [TAG_BITS-1:0]     held_request_tag, held_request_tag_next;
  logic [TAG_BITS-1:0]     held_order_tag, held_order_tag_next;
  logic [TIME_BITS-1:0]    sent_time, sent_time_next;
  logic [ATTEMPT_BITS-1:0] attempt_count, attempt_count_next;
  logic                    slow_reported, slow_reported_next;
  logic                    report_settled, report_settled_next;

  logic [TIME_BITS-1:0]    elapsed;
  logic                    overdue;
  logic                    fresh;
  logic                    live;

  // Overdue when time has not gone backward and the elapsed time reaches the timeout.
  assign elapsed = item.time_now - sent_time;
  assign overdue = (item.time_now >= sent_time) &&
                   (CMP_BITS'(elapsed) >= CMP_BITS'(ack_timeout));
  assign fresh   = item.report_time >= sent_time;
  assign live    = pending && !report_settled && fresh;

  // Decision logic for one item.
  always_comb begin
    pending_next          = pending;
    held_request_tag_next = held_request_tag;
    held_order_tag_next   = held_order_tag;
    sent_time_next        = sent_time;
    attempt_count_next    = attempt_count;
    slow_reported_next    = slow_reported;
    report_settled_next   = report_settled;
    result.outcome          = OUT_NONE;
    result.reported_status  = '0;
    result.result_order_tag = '0;

    unique case (item.action)
      ACT_SENT: begin
        pending_next          = 1'b1;
        held_request_tag_next = item.request_tag;
        held_order_tag_next   = item.order_tag;
        sent_time_next        = item.time_now;
        attempt_count_next    = ATTEMPT_BITS'(1);
        slow_reported_next    = 1'b0;
      end
      ACT_RESENT: begin
        held_request_tag_next = item.request_tag;
        sent_time_next        = item.time_now;
        if (attempt_count != '1) begin
          attempt_count_next = attempt_count + ATTEMPT_BITS'(1);
        end
        slow_reported_next = 1'b0;
      end
      ACT_CLEAR: begin
        pending_next          = 1'b0;
        held_request_tag_next = '0;
        held_order_tag_next   = '0;
        attempt_count_next    = '0;
        slow_reported_next    = 1'b0;
      end
      ACT_ENTRY: begin
        if (live && (item.request_tag == held_request_tag)) begin
          report_settled_next = 1'b1;
          if ((item.entry_status == ST_FINISHED) || (item.entry_status == ST_FAILED)) begin
            result.outcome = (item.entry_status == ST_FINISHED) ? OUT_FINISHED : OUT_FAILED;
            pending_next          = 1'b0;
            held_request_tag_next = '0;
            held_order_tag_next   = '0;
            attempt_count_next    = '0;
            slow_reported_next    = 1'b0;
          end else if (overdue && !slow_reported) begin
            slow_reported_next     = 1'b1;
            result.outcome         = OUT_RUNNING;
            result.reported_status = item.entry_status;
          end
        end
      end
      ACT_END: begin
        if (live) begin
          if (!((item.order_tag == held_order_tag) && item.order_has_work)) begin
            result.outcome        = OUT_GONE;
            pending_next          = 1'b0;
            held_request_tag_next = '0;
            held_order_tag_next   = '0;
            attempt_count_next    = '0;
            slow_reported_next    = 1'b0;
          end else if (overdue) begin
            result.result_order_tag = held_order_tag;
            if (attempt_count >= max_attempts) begin
              result.outcome        = OUT_UNANSWERED;
              pending_next          = 1'b0;
              held_request_tag_next = '0;
              held_order_tag_next   = '0;
              attempt_count_next    = '0;
              slow_reported_next    = 1'b0;
            end else begin
              result.outcome = OUT_RESEND;
            end
          end
        end
        report_settled_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Configuration and tracker state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout      <= TIMEOUT_RESET;
      max_attempts     <= ATTEMPTS_RESET;
      pending          <= 1'b0;
      held_request_tag <= '0;
      held_order_tag   <= '0;
      sent_time        <= '0;
      attempt_count    <= '0;
      slow_reported    <= 1'b0;
      report_settled   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ACK_TIMEOUT:  ack_timeout  <= TIMEOUT_BITS'(cfg_data);
          REG_MAX_ATTEMPTS: max_attempts <= ATTEMPT_BITS'(cfg_data);
          default: begin
          end
        endcase
      end
      if (step) begin
        pending          <= pending_next;
        held_request_tag <= held_request_tag_next;
        held_order_tag   <= held_order_tag_next;
        sent_time        <= sent_time_next;
        attempt_count    <= attempt_count_next;
        slow_reported    <= slow_reported_next;
        report_settled   <= report_settled_next;
      end
    end
  end

  // A pending request always has at least one send attempt on record.
  a_pending_has_attempt: assert property (@(posedge clk) disable iff (rst)
    pending |-> (attempt_count != '0))
    else $error("pending request with zero attempt count");

  // A final outcome leaves the tracker idle.
  a_final_drops: assert property (@(posedge clk) disable iff (rst)
    step && ((result.outcome == OUT_FINISHED) || (result.outcome == OUT_FAILED) ||
             (result.outcome == OUT_GONE) || (result.outcome == OUT_UNANSWERED))
    |=> !pending)
    else $error("tracker still pending after a final outcome");

  // A report end always reopens report framing.
  a_end_unsettles: assert property (@(posedge clk) disable iff (rst)
    step && (item.action == ACT_END) |=> !report_settled)
    else $error("report still settled after report end");

  // Still running is never reported twice for one send.
  a_running_once: assert property (@(posedge clk) disable iff (rst)
    step && (result.outcome == OUT_RUNNING) |-> !slow_reported)
    else $error("still running reported twice");

endmodule

`default_nettype wire

/* hw/rtl/cancel_request_tracker_unit.sv */
// Top level of the cancel request tracker: input register, tracker core, result register.
//
// Usage:
//   item_in   : input items (sent, resent, clear, action entry, report end).
//   result_out: exactly one result item per accepted input item, in order.
//   cfg       : register writes; index 0 is the acknowledge timeout, index 1 is
//               max_attempts. Always ready; write only while the block is idle.
// Path: an item passes the input register, then the tracker decision, then the
//   result register, where it is held until result_out takes it.
// Throughput: one item per cycle unless result_out stalls. Each decision is a
//   single pass of compares and one subtraction between the input and result
//   registers, and the tracker state updates in that same cycle, so the next item sees it.
// Reset: rst is synchronous and active high. It empties both registers, sets
//   the acknowledge timeout to 5000 and max_attempts to 3, and clears the tracker.
// Stalls: when result_out is not ready, the held result stays put, the
//   input register keeps one more item, and item_in ready drops only when
//   both are full.
`default_nettype none

module cancel_request_tracker_unit (
  input  logic clk,
  input  logic rst,
  crt_item_if.sink     item_in,
  crt_result_if.source result_out,
  crt_cfg_if.sink      cfg
);
  import crt_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_result;
  result_t core_result;
  logic    advance;

  // The held item moves on when the result register is free or being drained.
  assign advance       = in_valid && (!out_valid || result_out.ready);
  assign item_in.ready = !in_valid || advance;
  assign cfg.ready     = 1'b1;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_in.ready) begin
      in_valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.ready && item_in.valid) begin
      in_item.action         <= item_in.action;
      in_item.request_tag    <= item_in.request_tag;
      in_item.order_tag      <= item_in.order_tag;
      in_item.entry_status   <= item_in.entry_status;
      in_item.order_has_work <= item_in.order_has_work;
      in_item.report_time    <= item_in.report_time;
      in_item.time_now       <= item_in.time_now;
    end
  end

  crt_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .step      (advance),
    .item      (in_item),
    .result    (core_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign result_out.valid            = out_valid;
  assign result_out.outcome          = out_result.outcome;
  assign result_out.reported_status  = out_result.reported_status;
  assign result_out.result_order_tag = out_result.result_order_tag;

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the cancel request tracker, with its own prediction of every result.
`default_nettype none

module tb;
  import crt_pkg::*;

  // Action codes the block ignores, and entry status codes used by the stimulus.
  localparam logic [ACTION_BITS-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACTION_BITS-1:0] ACT_SPARE_HI = 3'd7;
  localparam logic [STATUS_BITS-1:0] ST_WAITING   = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_RUNNING   = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_PAUSED    = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_OTHER     = 3'd7;
  localparam logic [TIME_BITS-1:0]   TIME_MAX     = '1;
  localparam logic [TAG_BITS-1:0]    TAG_MAX      = '1;
  localparam int                     MAX_REPORTS  = 40;

  logic clk;
  logic rst;

  crt_item_if   item_bus ();
  crt_result_if result_bus ();
  crt_cfg_if    cfg_bus ();

  cancel_request_tracker_unit dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_bus),
    .result_out (result_bus),
    .cfg        (cfg_bus)
  );

  // Tracker state and register copies kept by the testbench.
  logic [TIMEOUT_BITS-1:0] conf_timeout;
  logic [ATTEMPT_BITS-1:0] conf_max_tries;
  logic                    req_pending;
  logic [TAG_BITS-1:0]     req_tag;
  logic [TAG_BITS-1:0]     ord_tag;
  logic [TIME_BITS-1:0]    sent_at;
  logic [ATTEMPT_BITS-1:0] tries;
  logic                    slow_flagged;
  logic                    report_done;

  result_t              awaited[$];
  int                   items_sent;
  int                   err_count;
  logic                 src_idle_on;
  logic                 sink_idle_on;
  int                   hold_cycles;
  int                   sink_burst;
  logic [TIME_BITS-1:0] tick;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Forget the held cancel request.
  function automatic void forget_request();
    req_pending  = 1'b0;
    req_tag      = '0;
    ord_tag      = '0;
    tries        = '0;
    slow_flagged = 1'b0;
  endfunction

  // The request is overdue once the timeout has elapsed; time running backward never is.
  function automatic logic is_late(logic [TIME_BITS-1:0] now);
    return (now >= sent_at) && ((now - sent_at) >= TIME_BITS'(conf_timeout));
  endfunction

  // Work out the result of one transfer and advance the tracker state.
  function automatic result_t track_cancel(item_t it);
    result_t r;
    logic    active;
    r = '0;
    case (it.action)
      ACT_SENT: begin
        req_pending  = 1'b1;
        req_tag      = it.request_tag;
        ord_tag      = it.order_tag;
        sent_at      = it.time_now;
        tries        = 8'd1;
        slow_flagged = 1'b0;
      end
      ACT_RESENT: begin
        req_tag      = it.request_tag;
        sent_at      = it.time_now;
        if (tries != '1) tries = tries + 8'd1;
        slow_flagged = 1'b0;
      end
      ACT_CLEAR: forget_request();
      ACT_ENTRY: begin
        if (req_pending && !report_done && it.report_time >= sent_at &&
            it.request_tag == req_tag) begin
          report_done = 1'b1;
          if (it.entry_status == ST_FINISHED || it.entry_status == ST_FAILED) begin
            r.outcome = (it.entry_status == ST_FINISHED) ? OUT_FINISHED : OUT_FAILED;
            forget_request();
          end else if (is_late(it.time_now) && !slow_flagged) begin
            slow_flagged      = 1'b1;
            r.outcome         = OUT_RUNNING;
            r.reported_status = it.entry_status;
          end
        end
      end
      ACT_END: begin
        if (req_pending && !report_done && it.report_time >= sent_at) begin
          active = (it.order_tag == ord_tag) && it.order_has_work;
          if (!active) begin
            forget_request();
            r.outcome = OUT_GONE;
          end else if (is_late(it.time_now)) begin
            r.result_order_tag = ord_tag;
            if (tries >= conf_max_tries) begin
              forget_request();
              r.outcome = OUT_UNANSWERED;
            end else begin
              r.outcome = OUT_RESEND;
            end
          end
        end
        report_done = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic item_t mk_item(logic [ACTION_BITS-1:0] act, logic [TAG_BITS-1:0] rtag,
                                    logic [TAG_BITS-1:0] otag, logic [STATUS_BITS-1:0] st,
                                    logic work, logic [TIME_BITS-1:0] rtime,
                                    logic [TIME_BITS-1:0] now);
    item_t it;
    it.action         = act;
    it.request_tag    = rtag;
    it.order_tag      = otag;
    it.entry_status   = st;
    it.order_has_work = work;
    it.report_time    = rtime;
    it.time_now       = now;
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (err_count < MAX_REPORTS)
      $display("%0t mismatch: %s got %0h want %0h", $realtime, what, got, want);
    err_count++;
  endtask

  // Offer one item, with an optional idle burst first, and predict its result on transfer.
  task automatic send_item(input item_t it);
    int gap;
    gap = (src_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (gap) begin
      @(negedge clk);
      item_bus.valid = 1'b0;
    end
    @(negedge clk);
    item_bus.action         = it.action;
    item_bus.request_tag    = it.request_tag;
    item_bus.order_tag      = it.order_tag;
    item_bus.entry_status   = it.entry_status;
    item_bus.order_has_work = it.order_has_work;
    item_bus.report_time    = it.report_time;
    item_bus.time_now       = it.time_now;
    item_bus.valid          = 1'b1;
    do @(posedge clk); while (!item_bus.ready);
    awaited.push_back(track_cancel(it));
    items_sent++;
  endtask

  // Stop offering items and wait until every expected result has come back.
  task automatic wait_drain();
    @(negedge clk);
    item_bus.valid = 1'b0;
    while (awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = value;
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx == REG_ACK_TIMEOUT) conf_timeout = value;
    else conf_max_tries = value[ATTEMPT_BITS-1:0];
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic set_config(input logic [31:0] tmo, input logic [31:0] max_tries);
    wait_drain();
    write_reg(REG_ACK_TIMEOUT, tmo);
    write_reg(REG_MAX_ATTEMPTS, max_tries);
  endtask

  // Time step between reports, spread around the timeout so both sides of the limit occur.
  function automatic logic [TIME_BITS-1:0] pick_advance();
    logic [63:0] span;
    span = {32'd0, conf_timeout};
    case ($urandom_range(0, 3))
      0: span = span - 64'($urandom_range(0, 2));
      1: span = span + 64'($urandom_range(0, 2));
      2: span = {$urandom, $urandom} % (span + 64'd1);
      default: span = 64'($urandom_range(0, 3));
    endcase
    return span[TIME_BITS-1:0];
  endfunction

  // One request life: sent, then report rounds with resends and clears, or a noise item.
  task automatic run_flow();
    logic [TAG_BITS-1:0]    cur_tag;
    logic [TAG_BITS-1:0]    ord;
    logic [TIME_BITS-1:0]   sent_t;
    logic [TIME_BITS-1:0]   rt;
    logic [TIME_BITS-1:0]   nw;
    logic [STATUS_BITS-1:0] st;
    int                     rounds;
    int                     entries;
    int                     pick;
    if ($urandom_range(0, 9) == 0) begin
      send_item(mk_item(ACTION_BITS'($urandom_range(0, 7)), TAG_BITS'($urandom),
                        TAG_BITS'($urandom), STATUS_BITS'($urandom_range(0, 7)),
                        1'($urandom_range(0, 1)), TIME_BITS'({$urandom, $urandom}),
                        TIME_BITS'({$urandom, $urandom})));
      return;
    end
    if ($urandom_range(0, 3) == 0) tick = TIME_BITS'({$urandom, $urandom});
    cur_tag = TAG_BITS'($urandom);
    ord     = TAG_BITS'($urandom);
    sent_t  = tick;
    send_item(mk_item(ACT_SENT, cur_tag, ord, STATUS_BITS'($urandom_range(0, 7)),
                      1'($urandom_range(0, 1)), TIME_BITS'({$urandom, $urandom}), tick));
    rounds = $urandom_range(1, 6);
    for (int r = 0; r < rounds && req_pending; r++) begin
      tick    = tick + pick_advance();
      entries = $urandom_range(0, 3);
      for (int e = 0; e < entries; e++) begin
        st = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? ST_FAILED : ST_FINISHED)
                                         : STATUS_BITS'($urandom_range(0, 7));
        rt = ($urandom_range(0, 9) == 0) ? sent_t - 48'd1 : tick;
        nw = ($urandom_range(0, 9) == 0) ? sent_t - TIME_BITS'($urandom_range(1, 5)) : tick;
        send_item(mk_item(ACT_ENTRY, ($urandom_range(0, 2) == 0) ? TAG_BITS'($urandom) : cur_tag,
                          TAG_BITS'($urandom), st, 1'($urandom_range(0, 1)), rt, nw));
      end
      rt = ($urandom_range(0, 9) == 0) ? sent_t - 48'd1 : tick;
      nw = ($urandom_range(0, 9) == 0) ? sent_t - TIME_BITS'($urandom_range(1, 5)) : tick;
      send_item(mk_item(ACT_END, TAG_BITS'($urandom),
                        ($urandom_range(0, 9) == 0) ? TAG_BITS'($urandom) : ord,
                        STATUS_BITS'($urandom_range(0, 7)), $urandom_range(0, 9) != 0,
                        rt, nw));
      // Occasionally clear, more often answer with a resend.
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        send_item(mk_item(ACT_CLEAR, TAG_BITS'($urandom), TAG_BITS'($urandom),
                          STATUS_BITS'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                          TIME_BITS'({$urandom, $urandom}),
                          TIME_BITS'({$urandom, $urandom})));
      end else if (pick < 8) begin
        if ($urandom_range(0, 1)) cur_tag = TAG_BITS'($urandom);
        sent_t = tick;
        send_item(mk_item(ACT_RESENT, cur_tag, TAG_BITS'($urandom),
                          STATUS_BITS'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                          TIME_BITS'({$urandom, $urandom}), tick));
      end
    end
  endtask

  // Reset values, idle behavior, report framing, every outcome, stale and backward time.
  task automatic test_directed_basics();
    send_item(mk_item(ACT_ENTRY, '0, '0, ST_FINISHED, 1'b1, '0, '0));
    send_item(mk_item(ACT_END, '0, '0, ST_WAITING, 1'b0, '0, '0));
    for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++)
      send_item(mk_item(ACTION_BITS'(a), TAG_MAX, TAG_MAX, ST_OTHER, 1'b1, TIME_MAX,
                        TIME_MAX));
    send_item(mk_item(ACT_RESENT, 16'h1234, 16'h0042, ST_WAITING, 1'b0, '0, 48'd100));
    send_item(mk_item(ACT_END, 16'h1234, '0, ST_WAITING, 1'b1, 48'd100, 48'd9000));
    // Start a request at time zero with all-ones tags.
    send_item(mk_item(ACT_SENT, TAG_MAX, TAG_MAX, ST_WAITING, 1'b0, '0, '0));
    send_item(mk_item(ACT_ENTRY, TAG_MAX, '0, ST_RUNNING, 1'b0, '0, 48'd4999));
    send_item(mk_item(ACT_ENTRY, TAG_MAX, '0, ST_FINISHED, 1'b0, '0, 48'd4999));
    send_item(mk_item(ACT_END, '0, TAG_MAX, ST_WAITING, 1'b1, '0, 48'd4999));
    send_item(mk_item(ACT_ENTRY, 16'hFFFE, '0, ST_FINISHED, 1'b0, 48'd10, 48'd5000));
    send_item(mk_item(ACT_ENTRY, TAG_MAX, '0, ST_PAUSED, 1'b0, 48'd10, 48'd5000));
    send_item(mk_item(ACT_END, '0, TAG_MAX, ST_WAITING, 1'b1, 48'd10, 48'd5000));
    send_item(mk_item(ACT_ENTRY, TAG_MAX, '0, ST_OTHER, 1'b0, 48'd10, 48'd6000));
    send_item(mk_item(ACT_END, '0, TAG_MAX, ST_WAITING, 1'b1, 48'd10, 48'd6000));
    send_item(mk_item(ACT_END, '0, TAG_MAX, ST_WAITING, 1'b1, 48'd10, 48'd5000));
    // Resends up to the attempt limit, with a stale report and time running backward.
    send_item(mk_item(ACT_RESENT, '0, '0, ST_WAITING, 1'b0, '0, 48'd10000));
    send_item(mk_item(ACT_ENTRY, '0, '0, ST_FINISHED, 1'b0, 48'd9999, 48'd20000));
    send_item(mk_item(ACT_END, '0, TAG_MAX, ST_WAITING, 1'b1, 48'd10000, 48'd9000));
    send_item(mk_item(ACT_END, '0, TAG_MAX, ST_WAITING, 1'b1, 48'd10000, 48'd15000));
    send_item(mk_item(ACT_RESENT, '0, '0, ST_WAITING, 1'b0, '0, 48'd20000));
    send_item(mk_item(ACT_END, '0, TAG_MAX, ST_WAITING, 1'b1, 48'd20000, 48'd25000));
    // Final entries, the first near the top of the time range, and an order that went away.
    send_item(mk_item(ACT_SENT, 16'd5, 16'd7, ST_WAITING, 1'b0, '0, TIME_MAX - 48'd6000));
    send_item(mk_item(ACT_ENTRY, 16'd5, '0, ST_FAILED, 1'b0, TIME_MAX, TIME_MAX));
    send_item(mk_item(ACT_SENT, 16'd5, 16'd7, ST_WAITING, 1'b0, '0, 48'd100));
    send_item(mk_item(ACT_END, '0, 16'd8, ST_WAITING, 1'b1, 48'd100, 48'd100));
    send_item(mk_item(ACT_SENT, 16'd5, 16'd7, ST_WAITING, 1'b0, '0, 48'd100));
    send_item(mk_item(ACT_END, '0, 16'd7, ST_WAITING, 1'b0, 48'd100, 48'd100));
    send_item(mk_item(ACT_SENT, 16'd9, 16'd7, ST_WAITING, 1'b0, '0, 48'd100));
    send_item(mk_item(ACT_ENTRY, 16'd9, '0, ST_FINISHED, 1'b0, 48'd100, 48'd100));
    send_item(mk_item(ACT_SENT, 16'd9, 16'd7, ST_WAITING, 1'b0, '0, 48'd100));
    send_item(mk_item(ACT_CLEAR, '0, '0, ST_WAITING, 1'b0, '0, '0));
    send_item(mk_item(ACT_END, '0, '0, ST_WAITING, 1'b1, TIME_MAX, TIME_MAX));
  endtask

  // Register extremes: zero timeout and zero limit, full-range timeout, a saturated counter.
  task automatic test_config_extremes();
    set_config('0, '0);
    send_item(mk_item(ACT_SENT, 16'd1, 16'd2, ST_WAITING, 1'b0, '0, 48'd50));
    send_item(mk_item(ACT_END, '0, 16'd2, ST_WAITING, 1'b1, 48'd50, 48'd50));
    send_item(mk_item(ACT_SENT, 16'd1, 16'd2, ST_WAITING, 1'b0, '0, TIME_MAX));
    send_item(mk_item(ACT_END, '0, 16'd2, ST_WAITING, 1'b1, TIME_MAX, TIME_MAX));
    // Only the low byte of the limit register counts.
    set_config('0, 32'hFFFF_FF02);
    send_item(mk_item(ACT_SENT, 16'd3, 16'd4, ST_WAITING, 1'b0, '0, 48'd7));
    send_item(mk_item(ACT_END, '0, 16'd4, ST_WAITING, 1'b1, 48'd7, 48'd7));
    send_item(mk_item(ACT_RESENT, 16'd3, '0, ST_WAITING, 1'b0, '0, 48'd8));
    send_item(mk_item(ACT_END, '0, 16'd4, ST_WAITING, 1'b1, 48'd8, 48'd8));
    set_config('1, 32'd255);
    send_item(mk_item(ACT_SENT, 16'd6, 16'd6, ST_WAITING, 1'b0, '0, '0));
    send_item(mk_item(ACT_END, '0, 16'd6, ST_WAITING, 1'b1, '0, 48'hFFFF_FFFE));
    send_item(mk_item(ACT_END, '0, 16'd6, ST_WAITING, 1'b1, '0, 48'hFFFF_FFFF));
    // Push the attempt counter past its top so it has to hold at the maximum.
    repeat (300) send_item(mk_item(ACT_RESENT, 16'd6, '0, ST_WAITING, 1'b0, '0, '0));
    send_item(mk_item(ACT_END, '0, 16'd6, ST_WAITING, 1'b1, '0, 48'hFFFF_FFFF));
    set_config(32'd5000, 32'd3);
  endtask

  // The receiver holds off long enough that the block fills and stalls its input.
  task automatic test_backpressure();
    int goal;
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    wait_drain();
    @(posedge clk);
    hold_cycles = 40;
    goal = items_sent + 16;
    while (items_sent < goal) run_flow();
    wait_drain();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // Phases of random request lives under changing settings; the last runs without idling.
  task automatic test_random_phases();
    logic [31:0] tmo;
    logic [31:0] cap;
    int          goal;
    for (int p = 0; p < 6; p++) begin
      case ($urandom_range(0, 5))
        0: tmo = '0;
        1, 2: tmo = $urandom_range(1, 40);
        3: tmo = $urandom_range(100, 6000);
        4: tmo = '1;
        default: tmo = $urandom;
      endcase
      case ($urandom_range(0, 5))
        0: cap = '0;
        1: cap = 32'd1;
        2: cap = {8'($urandom_range(0, 255)), 24'd0} | 32'd255;
        default: cap = $urandom_range(2, 6);
      endcase
      if (p == 0) begin
        tmo = 32'd20;
        cap = 32'd3;
      end
      if (p == 5) begin
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
      end
      set_config(tmo, cap);
      goal = items_sent + 240;
      while (items_sent < goal) run_flow();
    end
  endtask

  // Result ready: the long hold first, then random stall bursts.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      result_bus.ready = 1'b0;
      hold_cycles--;
    end else if (sink_burst > 0) begin
      result_bus.ready = 1'b0;
      sink_burst--;
    end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
      result_bus.ready = 1'b0;
      sink_burst = $urandom_range(0, 2);
    end else begin
      result_bus.ready = 1'b1;
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (awaited.size() == 0) begin
        report_mismatch("result with none expected, outcome", result_bus.outcome, '0);
      end else begin
        want = awaited.pop_front();
        if (result_bus.outcome !== want.outcome)
          report_mismatch("outcome", result_bus.outcome, want.outcome);
        if (result_bus.reported_status !== want.reported_status)
          report_mismatch("reported_status", result_bus.reported_status,
                          want.reported_status);
        if (result_bus.result_order_tag !== want.result_order_tag)
          report_mismatch("result_order_tag", result_bus.result_order_tag,
                          want.result_order_tag);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    clk                     = 1'b0;
    rst                     = 1'b1;
    item_bus.valid          = 1'b0;
    item_bus.action         = ACT_SENT;
    item_bus.request_tag    = '0;
    item_bus.order_tag      = '0;
    item_bus.entry_status   = ST_WAITING;
    item_bus.order_has_work = 1'b0;
    item_bus.report_time    = '0;
    item_bus.time_now       = '0;
    result_bus.ready        = 1'b0;
    cfg_bus.valid           = 1'b0;
    cfg_bus.index           = REG_ACK_TIMEOUT;
    cfg_bus.data            = '0;
    conf_timeout            = TIMEOUT_RESET;
    conf_max_tries          = ATTEMPTS_RESET;
    forget_request();
    sent_at                 = '0;
    report_done             = 1'b0;
    items_sent              = 0;
    err_count               = 0;
    src_idle_on             = 1'b1;
    sink_idle_on            = 1'b1;
    hold_cycles             = 0;
    sink_burst              = 0;
    tick                    = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_basics();
    test_config_extremes();
    test_backpressure();
    test_random_phases();

    wait_drain();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
